@@ hw/rtl/ssc_pkg.sv @@
// Shared types and constants for the subset sum counter.
package ssc_pkg;

    // Fixed field widths
    localparam int TARGET_W  = 10;
    localparam int ELEMENT_W = 16;
    localparam int OUT_W     = 32;

    // Input transaction payload
    typedef struct packed {
        logic [ELEMENT_W-1:0] element_value;
        logic                 first_element;
        logic                 last_element;
    } in_item_t;

    // Result transaction payload
    typedef struct packed {
        logic [OUT_W-1:0] way_count;
        logic             count_overflow;
    } out_item_t;

    // Control from the sequencer to the count row
    typedef struct packed {
        logic issue;     // read pair now, write back next cycle
        logic add;       // write back the saturated sum, else the reset value
        logic ovf_clr;   // clear the sticky overflow flag
    } row_ctl_t;

endpackage

@@ hw/rtl/subset_sum_count_top.sv @@
// Subset sum counter: sequencer, target register and result register.
//
// Each accepted element v at or below the target t rewrites the count row from
// t down to v, one entry per cycle through the single write port of the count
// memory, and further down to the lowest entry never touched since the last
// first item when the row grows past such entries. An element above the target
// skips the row pass. An item marked last also reads the count at the target
// and places the result. The row needs no clearing pass: a fill count marks
// which entries hold live counts and the rest read as one at sum zero and zero
// elsewhere, both after reset and after an item marked first. The target
// register may be written only while the block is idle; targets above
// MAX_TARGET act as MAX_TARGET.
module subset_sum_count_top #(
    parameter int MAX_TARGET = 1023,
    parameter int COUNT_BITS = 32
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  ssc_pkg::in_item_t              in_data,
    output logic                           out_valid,
    input  logic                           out_stall,
    output ssc_pkg::out_item_t             out_data,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [ssc_pkg::TARGET_W-1:0]   cfg_data
);
    import ssc_pkg::*;

    localparam int ROW_LEN = MAX_TARGET + 1;
    localparam int AW      = $clog2(ROW_LEN);
    localparam int FW      = $clog2(ROW_LEN + 1);
    localparam logic [16:0] MAX_T17 = 17'(MAX_TARGET);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RUN,
        ST_WB,
        ST_RD,
        ST_RES,
        ST_EMIT
    } state_t;

    state_t                 state_reg, state_next;
    logic [TARGET_W-1:0]    target_reg;
    logic [AW-1:0]          s_reg, s_next;
    logic [AW-1:0]          lo_reg, lo_next;
    logic [AW-1:0]          v_reg, v_next;
    logic [AW-1:0]          t_reg, t_next;
    logic                   last_reg, last_next;
    logic [FW-1:0]          fill_reg, fill_next;
    logic [FW-1:0]          fill_new_reg, fill_new_next;
    logic                   out_valid_reg, out_valid_next;
    out_item_t              out_reg, out_next;
    out_item_t              pend_reg, pend_next;

    logic                   in_accept;
    logic [16:0]            t_eff17;
    logic [16:0]            v17;
    logic                   do_update;
    logic [FW-1:0]          fill_use;
    logic [FW-1:0]          tp1;
    logic                   extend;
    logic [16:0]            lo17;

    row_ctl_t               ctl;
    logic [AW-1:0]          addr_a;
    logic [AW-1:0]          addr_b;
    logic [COUNT_BITS-1:0]  rd_count;
    logic                   row_ovf;
    logic [63:0]            count_ext;
    logic                   count_high;

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // Hold the target register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            target_reg <= cfg_data;
        end
    end

    // Decode the incoming transaction against the effective target
    always_comb
    begin
        t_eff17   = (17'(target_reg) > MAX_T17) ? MAX_T17 : 17'(target_reg);
        v17       = 17'(in_data.element_value);
        do_update = (v17 <= t_eff17);
        fill_use  = in_data.first_element ? '0 : fill_reg;
        tp1       = FW'(t_eff17) + FW'(1);
        extend    = (tp1 > fill_use);
        lo17      = (extend && (17'(fill_use) < v17)) ? 17'(fill_use) : v17;
    end

    // Clip a count wider than the result field
    always_comb
    begin
        count_ext  = 64'(rd_count);
        count_high = |count_ext[63:32];
    end

    // Sequence the row pass and the result read
    always_comb
    begin
        state_next     = state_reg;
        s_next         = s_reg;
        lo_next        = lo_reg;
        v_next         = v_reg;
        t_next         = t_reg;
        last_next      = last_reg;
        fill_next      = fill_reg;
        fill_new_next  = fill_new_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        pend_next      = pend_reg;
        ctl            = '0;
        addr_a         = s_reg;
        addr_b         = s_reg - v_reg;

        // Drop the result once the consumer takes it
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    ctl.ovf_clr   = in_data.first_element;
                    fill_next     = fill_use;
                    fill_new_next = extend ? tp1 : fill_use;
                    t_next        = AW'(t_eff17);
                    v_next        = AW'(v17);
                    lo_next       = AW'(lo17);
                    s_next        = AW'(t_eff17);
                    last_next     = in_data.last_element;
                    if (do_update)
                    begin
                        state_next = ST_RUN;
                    end
                    else if (in_data.last_element)
                    begin
                        state_next = ST_RD;
                    end
                end
            end
            ST_RUN:
            begin
                ctl.issue = 1'b1;
                ctl.add   = (s_reg >= v_reg);
                if (s_reg == lo_reg)
                begin
                    state_next = ST_WB;
                end
                else
                begin
                    s_next = s_reg - AW'(1);
                end
            end
            ST_WB:
            begin
                fill_next  = fill_new_reg;
                state_next = last_reg ? ST_RD : ST_IDLE;
            end
            ST_RD:
            begin
                addr_a     = t_reg;
                state_next = ST_RES;
            end
            ST_RES:
            begin
                pend_next.way_count      = count_high ? '1 : count_ext[31:0];
                pend_next.count_overflow = row_ovf || count_high;
                state_next               = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_next       = pend_reg;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold state, fill count and the result valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            fill_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Hold pass bounds and result payload
    always_ff @(posedge clk)
    begin
        s_reg        <= s_next;
        lo_reg       <= lo_next;
        v_reg        <= v_next;
        t_reg        <= t_next;
        last_reg     <= last_next;
        fill_new_reg <= fill_new_next;
        out_reg      <= out_next;
        pend_reg     <= pend_next;
    end

    ssc_row #(
        .ROW_LEN    (ROW_LEN),
        .COUNT_BITS (COUNT_BITS)
    ) u_row (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (ctl),
        .addr_a   (addr_a),
        .addr_b   (addr_b),
        .fill     (fill_reg),
        .rd_count (rd_count),
        .ovf      (row_ovf)
    );

endmodule

@@ hw/rtl/ssc_row.sv @@
// Count row memory with fill-count masking and saturating write-back stage.
module ssc_row #(
    parameter int ROW_LEN    = 1024,
    parameter int COUNT_BITS = 32
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  ssc_pkg::row_ctl_t                ctl,
    input  logic [$clog2(ROW_LEN)-1:0]       addr_a,
    input  logic [$clog2(ROW_LEN)-1:0]       addr_b,
    input  logic [$clog2(ROW_LEN+1)-1:0]     fill,
    output logic [COUNT_BITS-1:0]            rd_count,
    output logic                             ovf
);
    import ssc_pkg::*;

    localparam int AW = $clog2(ROW_LEN);
    localparam int FW = $clog2(ROW_LEN + 1);

    logic [COUNT_BITS-1:0] mem [ROW_LEN];

    logic [COUNT_BITS-1:0] rd_a_reg;
    logic [COUNT_BITS-1:0] rd_b_reg;
    logic [AW-1:0]         p_addr_a_reg;
    logic [AW-1:0]         p_addr_b_reg;
    logic                  p_add_reg;
    logic                  p_valid_reg;
    logic                  ovf_reg;

    logic [COUNT_BITS-1:0] val_a;
    logic [COUNT_BITS-1:0] val_b;
    logic [COUNT_BITS-1:0] rst_a;
    logic [COUNT_BITS:0]   sum;
    logic                  carry;
    logic [COUNT_BITS-1:0] wr_data;

    // Read both ports every cycle, write back from the second stage
    always_ff @(posedge clk)
    begin
        rd_a_reg <= mem[addr_a];
        rd_b_reg <= mem[addr_b];
        if (p_valid_reg)
        begin
            mem[p_addr_a_reg] <= wr_data;
        end
    end

    // Hold addresses of the reads in flight
    always_ff @(posedge clk)
    begin
        p_addr_a_reg <= addr_a;
        p_addr_b_reg <= addr_b;
        p_add_reg    <= ctl.add;
    end

    // Track the write-back stage and the sticky overflow flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_valid_reg <= 1'b0;
            ovf_reg     <= 1'b0;
        end
        else
        begin
            p_valid_reg <= ctl.issue;
            if (ctl.ovf_clr)
            begin
                ovf_reg <= 1'b0;
            end
            else if (p_valid_reg && p_add_reg && carry)
            begin
                ovf_reg <= 1'b1;
            end
        end
    end

    // Entries at or above the fill count read as the cleared row
    always_comb
    begin
        rst_a = COUNT_BITS'(p_addr_a_reg == '0);
        val_a = (FW'(p_addr_a_reg) < fill) ? rd_a_reg : rst_a;
        val_b = (FW'(p_addr_b_reg) < fill) ? rd_b_reg
                                           : COUNT_BITS'(p_addr_b_reg == '0);
    end

    // Saturate the sum at the top of the count width
    always_comb
    begin
        sum   = {1'b0, val_a} + {1'b0, val_b};
        carry = sum[COUNT_BITS];
        if (p_add_reg)
        begin
            wr_data = carry ? '1 : sum[COUNT_BITS-1:0];
        end
        else
        begin
            wr_data = rst_a;
        end
    end

    assign rd_count = val_a;
    assign ovf      = ovf_reg;

endmodule

@@ sim/testbench.sv @@
// Testbench for the subset sum counter: directed sets, random sets and a result scoreboard.
`timescale 1ns / 1ps

module testbench;
    import ssc_pkg::*;

    localparam int ROW_TOP       = 1023;    // matches MAX_TARGET of the block
    localparam int SETTLE_CYCLES = 1100;    // worst item plus result placement
    localparam int STUCK_LIMIT   = 10000;   // cycles without any transaction

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    in_item_t           in_data = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    out_item_t          out_data;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [TARGET_W-1:0] cfg_data = '0;

    // Predictor state: one row of way counts, the sticky flag and the target
    bit [31:0]          count_row [0:ROW_TOP];
    bit                 sticky_ovf;
    bit [TARGET_W-1:0]  target_reg;
    out_item_t          expected_counts [$];

    bit                 idle_on = 1'b1;
    int                 error_count = 0;
    int                 elements_sent = 0;
    int                 results_checked = 0;
    int                 saturated_seen = 0;
    int                 target_writes = 0;
    int                 stuck_cycles = 0;

    subset_sum_count_top u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    // Reset the row to one way of reaching sum zero
    function automatic void clear_count_row();
        foreach (count_row[i])
            count_row[i] = '0;
        count_row[0] = 32'd1;
        sticky_ovf   = 1'b0;
    endfunction

    // Fold one accepted element into the row; queue the count on a last item
    function automatic void apply_element(in_item_t item);
        int        t;
        int        v;
        bit [32:0] total;
        out_item_t res;
        t = (target_reg > ROW_TOP) ? ROW_TOP : target_reg;
        v = item.element_value;
        if (item.first_element)
            clear_count_row();
        if (v <= t) begin
            // walk downward so each element is used at most once
            for (int s = t; s >= v; s--) begin
                total = {1'b0, count_row[s]} + count_row[s - v];
                if (total[32]) begin
                    sticky_ovf   = 1'b1;
                    count_row[s] = '1;
                end
                else
                    count_row[s] = total[31:0];
            end
        end
        if (item.last_element) begin
            res.way_count      = count_row[t];
            res.count_overflow = sticky_ovf;
            expected_counts.push_back(res);
        end
    endfunction

    // Drive one element, hold it through stalls, predict on acceptance
    task automatic send_item(input in_item_t item);
        while (idle_on && $urandom_range(0, 99) < 33) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        apply_element(item);
        elements_sent++;
        @(negedge clk);
    endtask

    task automatic send_element(input int value, input bit first, input bit last);
        in_item_t item;
        item.element_value = value[ELEMENT_W-1:0];
        item.first_element = first;
        item.last_element  = last;
        send_item(item);
    endtask

    // Drop valid and wait for every queued count to come back
    task automatic hold_until_drained();
        in_valid <= 1'b0;
        while (expected_counts.size() != 0)
            @(negedge clk);
    endtask

    // Write the target once the block has finished all work in flight
    task automatic set_target(input int value);
        hold_until_drained();
        repeat (SETTLE_CYCLES) @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value[TARGET_W-1:0];
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        target_reg = value[TARGET_W-1:0];
        target_writes++;
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    // Mostly elements within the target, some zeros, some just above, some anywhere
    function automatic logic [ELEMENT_W-1:0] pick_element(input int t, input int zero_pct);
        int r;
        r = $urandom_range(0, 99);
        if (r < zero_pct)
            return '0;
        r = $urandom_range(0, 9);
        if (r < 7)
            return ELEMENT_W'($urandom_range(0, t));
        if (r == 7)
            return ELEMENT_W'($urandom_range(t + 1, t + 2));
        return ELEMENT_W'($urandom());
    endfunction

    // Row continues from reset when no first item has been seen
    task automatic test_no_first_after_reset();
        send_element(0, 1'b0, 1'b1);
        send_element(16'hFFFF, 1'b0, 1'b1);
    endtask

    // Largest target with elements at, below and above it
    task automatic test_field_extremes();
        set_target(ROW_TOP);
        send_element(ROW_TOP, 1'b1, 1'b1);
        send_element(16'hFFFF, 1'b1, 1'b0);
        send_element(1, 1'b0, 1'b0);
        send_element(ROW_TOP - 1, 1'b0, 1'b0);
        send_element(512, 1'b0, 1'b0);
        send_element(511, 1'b0, 1'b0);
        send_element(0, 1'b0, 1'b0);
        send_element(ROW_TOP + 1, 1'b0, 1'b1);
    endtask

    // Target zero: only zeros count, each one doubles
    task automatic test_target_zero();
        set_target(0);
        send_element(0, 1'b1, 1'b1);
        send_element(0, 1'b1, 1'b0);
        send_element(16'hFFFF, 1'b0, 1'b0);
        send_element(0, 1'b0, 1'b1);
    endtask

    // Change the target while a set is open; earlier sums stay as they were
    task automatic test_target_change_mid_set();
        set_target(10);
        send_element(3, 1'b1, 1'b0);
        send_element(7, 1'b0, 1'b0);
        set_target(4);
        send_element(1, 1'b0, 1'b0);
        send_element(3, 1'b0, 1'b1);
        set_target(12);
        send_element(2, 1'b0, 1'b1);
    endtask

    // Random sets per target phase: well-formed, long zero-heavy, and noise
    task automatic test_random_sets();
        int        phase_target [10] = '{3, 12, 31, 64, 200, ROW_TOP, 9, 127, 0, 511};
        int        phase_quota  [10] = '{70, 70, 70, 65, 55, 15, 70, 60, 55, 20};
        int        sent;
        int        kind;
        int        n;
        int        zero_pct;
        bit        f;
        bit        l;
        in_item_t  item;
        for (int p = 0; p < 10; p++) begin
            set_target(phase_target[p]);
            // one phase runs with no idling on either side
            idle_on = (p != 2);
            sent = 0;
            while (sent < phase_quota[p]) begin
                kind = $urandom_range(0, 99);
                if (kind < 10) begin
                    n = $urandom_range(1, 6);
                    zero_pct = 8;
                end
                else if (kind < 22) begin
                    // long enough for zeros to push counts into saturation
                    n = $urandom_range(36, 44);
                    zero_pct = 85;
                end
                else begin
                    n = $urandom_range(1, 12);
                    zero_pct = 8;
                end
                for (int i = 0; i < n; i++) begin
                    if (kind < 10) begin
                        f = ($urandom_range(0, 9) == 0);
                        l = ($urandom_range(0, 3) == 0);
                    end
                    else begin
                        f = (i == 0);
                        l = (i == n - 1);
                    end
                    item.element_value = pick_element(phase_target[p], zero_pct);
                    item.first_element = f;
                    item.last_element  = l;
                    send_item(item);
                end
                sent += n;
                // now and then let the result side run dry before the next set
                if (kind >= 10 && $urandom_range(0, 11) == 0)
                    hold_until_drained();
            end
        end
        idle_on = 1'b1;
    endtask

    // Result side stall
    always @(negedge clk)
        out_stall <= idle_on && ($urandom_range(0, 99) < 33);

    // Compare each result transaction with the oldest expected count
    always @(posedge clk) begin : check_results
        out_item_t want;
        if (rst_n && out_valid && !out_stall) begin
            if (expected_counts.size() == 0) begin
                $display("%0t: unexpected result way_count=%0d count_overflow=%0b",
                         $time, out_data.way_count, out_data.count_overflow);
                error_count++;
            end
            else begin
                want = expected_counts.pop_front();
                results_checked++;
                if (out_data.count_overflow)
                    saturated_seen++;
                if (out_data.way_count !== want.way_count) begin
                    $display("%0t: way_count mismatch: expected %0d, actual %0d",
                             $time, want.way_count, out_data.way_count);
                    error_count++;
                end
                if (out_data.count_overflow !== want.count_overflow) begin
                    $display("%0t: count_overflow mismatch: expected %0b, actual %0b",
                             $time, want.count_overflow, out_data.count_overflow);
                    error_count++;
                end
            end
        end
    end

    // End the run if no transaction moves for too long
    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            stuck_cycles <= 0;
        else if (stuck_cycles >= STUCK_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $time, STUCK_LIMIT);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
        else
            stuck_cycles <= stuck_cycles + 1;
    end

    initial begin
        clear_count_row();
        target_reg = '0;
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_no_first_after_reset();
        test_field_extremes();
        test_target_zero();
        test_target_change_mid_set();
        test_random_sets();

        hold_until_drained();
        repeat (SETTLE_CYCLES) @(negedge clk);

        $display("Sent %0d elements across targets 0 to %0d, %0d target writes, with stalls",
                 elements_sent, ROW_TOP, target_writes);
        $display("on both sides; checked %0d counts, %0d of them with the overflow flag set.",
                 results_checked, saturated_seen);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
